[sv/assert_macros.svh]
// Assertion macros used by the core RTL of the router priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication checked at every rising clock edge outside reset.
`define RDPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define RDPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rdpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpq_pkg
// Types, codes and the ordering key of the router priority queue.
// ----------------------------------------------------------------------------
package rdpq_pkg;

  typedef enum logic [1:0] {
    FN_INSERT  = 2'd0,
    FN_POP_MIN = 2'd1,
    FN_POP_MAX = 2'd2
  } rdpq_func_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } rdpq_status_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [3:0] ports;
    logic [6:0] cpu;
  } rdpq_rec_t;

  typedef logic [18:0] rdpq_key_t;

  // Control broadcast to every cell for one accepted beat.
  typedef struct packed {
    logic      insert;
    logic      pop_min;
    logic      pop_max;
    rdpq_rec_t rec;
  } rdpq_ctrl_t;

  // Loads first, then the address, so that ties on the loads fall to the address.
  function automatic rdpq_key_t rdpq_key(input rdpq_rec_t r);
    return {r.ports, r.cpu, r.addr};
  endfunction

endpackage

[sv/rdpq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpq_in_if / rdpq_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface rdpq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] node_addr;
  logic [3:0] port_load;
  logic [6:0] cpu_load;

  modport source (output valid, func, node_addr, port_load, cpu_load, input ready);
  modport sink (input valid, func, node_addr, port_load, cpu_load, output ready);
endinterface

interface rdpq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_addr;
  logic [3:0] out_ports;
  logic [6:0] out_cpu;
  logic [4:0] occupancy;

  modport source (output valid, status, out_addr, out_ports, out_cpu, occupancy,
                  input ready);
  modport sink (input valid, status, out_addr, out_ports, out_cpu, occupancy,
                output ready);
endinterface

[sv/rdpq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpq_cell
// One sorted-chain slot; shifts tailward on insert and headward on a min pop.
// ----------------------------------------------------------------------------
module rdpq_cell
  import rdpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rdpq_ctrl_t ctrl,
  input  rdpq_rec_t  left_rec,
  input  logic       left_valid,
  input  logic       left_stays,
  input  rdpq_rec_t  right_rec,
  input  logic       right_valid,
  output rdpq_rec_t  rec,
  output logic       valid,
  output logic       stays
);

  rdpq_rec_t rec_r, rec_nxt;
  logic      valid_r, valid_nxt;

  assign stays = valid_r && (rdpq_key(rec_r) <= rdpq_key(ctrl.rec));

  always_comb begin
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    if (ctrl.insert) begin
      if (!stays) begin
        if (left_stays) begin
          rec_nxt   = ctrl.rec;
          valid_nxt = 1'b1;
        end else begin
          rec_nxt   = left_rec;
          valid_nxt = left_valid;
        end
      end
    end else if (ctrl.pop_min) begin
      rec_nxt   = right_rec;
      valid_nxt = right_valid;
    end else if (ctrl.pop_max) begin
      valid_nxt = valid_r && right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec   = rec_r;
  assign valid = valid_r;

endmodule

[sv/router_double_ended_priority_queue_core.sv]
`timescale 1ns / 1ps
// The result beat of an accepted operation beat appears in the cycle after it.
// Throughput: one op per cycle while results are taken; all cells update together.
// A result waiting in the output register does not stop the next beat if it is taken.
// Reset empties the chain by clearing every valid bit and the held count.
// ----------------------------------------------------------------------------
// router_double_ended_priority_queue_core
// Double-ended priority queue of router records kept sorted in a chain of cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module router_double_ended_priority_queue_core
  import rdpq_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  rdpq_in_if.sink      in_ch,
  rdpq_out_if.source   out_ch
);

  localparam int CW = $clog2(ENTRIES + 1);

  rdpq_rec_t          cell_rec [ENTRIES];
  logic [ENTRIES-1:0] cell_valid;
  logic [ENTRIES-1:0] cell_stays;
  rdpq_ctrl_t         ctrl;

  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;
  rdpq_status_t   status_r, status_nxt;
  rdpq_rec_t      res_r, res_nxt;
  logic [4:0]     occ_r, occ_nxt;
  logic [CW+4:0]  occ_ext;

  logic       accept;
  logic       full;
  logic       empty;
  logic       is_insert;
  logic       is_max;
  rdpq_rec_t  in_rec;
  rdpq_rec_t  max_rec;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CW'(ENTRIES));
  assign empty       = (count_r == '0);
  assign in_rec      = '{addr: in_ch.node_addr, ports: in_ch.port_load, cpu: in_ch.cpu_load};

  always_comb begin
    is_insert = 1'b0;
    is_max    = 1'b0;
    case (rdpq_func_t'(in_ch.func))
      FN_INSERT:  is_insert = 1'b1;
      FN_POP_MIN: is_max    = 1'b0;
      default:    is_max    = 1'b1;
    endcase
  end

  always_comb begin
    ctrl.rec     = in_rec;
    ctrl.insert  = accept && is_insert && !full;
    ctrl.pop_min = accept && !is_insert && !is_max && !empty;
    ctrl.pop_max = accept && !is_insert && is_max && !empty;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rdpq_rec_t l_rec, r_rec;
    logic      l_valid, l_stays, r_valid;
    if (i == 0) begin : g_first
      assign l_rec   = '0;
      assign l_valid = 1'b0;
      assign l_stays = 1'b1;
    end else begin : g_mid_l
      assign l_rec   = cell_rec[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_stays = cell_stays[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign r_rec   = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_rec   = cell_rec[i+1];
      assign r_valid = cell_valid[i+1];
    end
    rdpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_rec    (l_rec),
      .left_valid  (l_valid),
      .left_stays  (l_stays),
      .right_rec   (r_rec),
      .right_valid (r_valid),
      .rec         (cell_rec[i]),
      .valid       (cell_valid[i]),
      .stays       (cell_stays[i])
    );
  end

  // The largest record sits in the last valid cell of the chain.
  always_comb begin
    max_rec = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_valid[i] && ((i == ENTRIES - 1) || !cell_valid[(i + 1) % ENTRIES])) begin
        max_rec = max_rec | cell_rec[i];
      end
    end
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    res_nxt       = res_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (is_insert) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + CW'(1);
        end
      end else if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_POPPED;
        count_nxt  = count_r - CW'(1);
        res_nxt    = is_max ? max_rec : cell_rec[0];
      end
    end
  end

  assign occ_ext = {5'b0, count_nxt};

  always_comb begin
    occ_nxt = accept ? occ_ext[4:0] : occ_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    res_r    <= res_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_addr  = res_r.addr;
  assign out_ch.out_ports = res_r.ports;
  assign out_ch.out_cpu   = res_r.cpu;
  assign out_ch.occupancy = occ_r;

  `RDPQ_ASSERT_NOW(a_count_matches_cells, clk, rst_n, 1'b1, $countones(cell_valid) == count_r, "held count differs from valid cells")
  `RDPQ_ASSERT_NOW(a_head_valid, clk, rst_n, 1'b1, cell_valid[0] == (count_r != '0), "head cell validity differs from held count")
  `RDPQ_ASSERT_NOW(a_empty_status, clk, rst_n, out_valid_r && (status_r == ST_EMPTY), count_r == '0, "empty status reported while records are held")
  `RDPQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, accept && is_insert && !full, count_r == $past(count_r) + CW'(1), "accepted insert did not grow the count")

endmodule

[sim/tb_router_double_ended_priority_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_router_double_ended_priority_queue_core
// Self-checking bench for the router record queue. It runs a short table of
// directed operations covering empty pops, extreme records, load ties and a
// full store. After that come random phases that lean toward inserts or pops,
// so the store swings between empty and full. Each result is compared with a
// fixed table result or with a model of the store updated on each accepted beat.
// ----------------------------------------------------------------------------
module tb_router_double_ended_priority_queue_core;
  import rdpq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RANDOM_OPS = 920;
  localparam logic [1:0] FN_POP_MAX_ALIAS = 2'd3;

  typedef struct packed {
    rdpq_status_t status;
    logic [7:0]   addr;
    logic [3:0]   ports;
    logic [6:0]   cpu;
    logic [4:0]   occ;
  } dpq_result_t;

  typedef struct packed {
    logic [1:0]  func;
    rdpq_rec_t   rec;
    logic        typed;
    dpq_result_t result;
  } stim_row_t;

  logic clk;
  logic rst_n;

  rdpq_in_if  in_ch ();
  rdpq_out_if out_ch ();

  router_double_ended_priority_queue_core #(
    .ENTRIES(QUEUE_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rdpq_rec_t   model_recs[QUEUE_DEPTH];
  int          model_count;
  dpq_result_t pending_results[$];
  stim_row_t   stim_rows[$];
  logic        typed_check;
  dpq_result_t typed_res;
  int          error_count;
  int          hold_token;
  int          hold_seen;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [18:0] load_rank(input rdpq_rec_t r);
    return {r.ports, r.cpu, r.addr};
  endfunction

  function automatic dpq_result_t dpq_apply(input logic [1:0] fn, input rdpq_rec_t rec);
    dpq_result_t res;
    int          best;
    int          i;
    logic [18:0] best_key;
    logic [18:0] k;
    logic        want_max;
    res = '0;
    if (fn == FN_INSERT) begin
      if (model_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        model_recs[model_count] = rec;
        model_count++;
        res.status = ST_INSERTED;
      end
    end else if (model_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      want_max = fn[1];
      best = 0;
      best_key = load_rank(model_recs[0]);
      for (i = 1; i < model_count; i++) begin
        k = load_rank(model_recs[i]);
        if (want_max ? (k > best_key) : (k < best_key)) begin
          best = i;
          best_key = k;
        end
      end
      res.addr = model_recs[best].addr;
      res.ports = model_recs[best].ports;
      res.cpu = model_recs[best].cpu;
      model_count--;
      model_recs[best] = model_recs[model_count];
      res.status = ST_POPPED;
    end
    res.occ = model_count[4:0];
    return res;
  endfunction

  function automatic rdpq_rec_t rand_rec();
    rdpq_rec_t r;
    r.addr = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      r.ports = 4'($urandom_range(6, 7));
      r.cpu = 7'($urandom_range(40, 41));
    end else begin
      r.ports = 4'($urandom_range(0, 15));
      r.cpu = 7'($urandom_range(0, 127));
    end
    return r;
  endfunction

  function automatic logic [1:0] rand_func(input int insert_pct);
    int pick;
    if ($urandom_range(0, 99) < insert_pct) begin
      return FN_INSERT;
    end
    pick = $urandom_range(0, 4);
    if (pick == 0) begin
      return FN_POP_MAX_ALIAS;
    end else if (pick < 3) begin
      return FN_POP_MIN;
    end
    return FN_POP_MAX;
  endfunction

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      error_count++;
    end
  endtask

  task automatic push_row(input logic [1:0] fn, input int addr, input int ports, input int cpu,
                          input logic typed, input rdpq_status_t st, input int eaddr,
                          input int eports, input int ecpu, input int occ);
    stim_row_t row;
    row.func = fn;
    row.rec.addr = 8'(addr);
    row.rec.ports = 4'(ports);
    row.rec.cpu = 7'(cpu);
    row.typed = typed;
    row.result.status = st;
    row.result.addr = 8'(eaddr);
    row.result.ports = 4'(eports);
    row.result.cpu = 7'(ecpu);
    row.result.occ = 5'(occ);
    stim_rows = {stim_rows, row};
  endtask

  task automatic offer_op(input logic [1:0] fn, input rdpq_rec_t rec, input logic typed,
                          input dpq_result_t fixed_res);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.node_addr <= rec.addr;
    in_ch.port_load <= rec.ports;
    in_ch.cpu_load <= rec.cpu;
    typed_check <= typed;
    typed_res <= fixed_res;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int n_ops, input int insert_pct, input logic dense);
    int burst_left;
    int n;
    burst_left = $urandom_range(1, 24);
    for (n = 0; n < n_ops; n++) begin
      offer_op(rand_func(insert_pct), rand_rec(), 1'b0, '0);
      burst_left--;
      if (burst_left == 0) begin
        idle_cycles(dense ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  always @(posedge clk) begin
    dpq_result_t predicted;
    dpq_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = dpq_apply(in_ch.func, {in_ch.node_addr, in_ch.port_load, in_ch.cpu_load});
        predicted = typed_check ? typed_res : predicted;
        pending_results = {pending_results, predicted};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d addr %0d", $time,
                   out_ch.status, out_ch.out_addr);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", int'(want.status), int'(out_ch.status));
          check_field("out_addr", int'(want.addr), int'(out_ch.out_addr));
          check_field("out_ports", int'(want.ports), int'(out_ch.out_ports));
          check_field("out_cpu", int'(want.cpu), int'(out_ch.out_cpu));
          check_field("occupancy", int'(want.occ), int'(out_ch.occupancy));
        end
      end
    end
  end

  initial begin
    int          hold_left;
    int          pos;
    logic [15:0] pattern;
    logic        no_stall;
    hold_seen = 0;
    hold_left = 0;
    pos = 0;
    pattern = '1;
    no_stall = 1'b1;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = $urandom_range(60, 100);
      end
      if (pos == 0) begin
        no_stall = ($urandom_range(0, 2) == 0);
        pattern = 16'($urandom);
      end
      pos = (pos + 1) % 64;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_stall ? 1'b1 : pattern[pos % 16];
      end
    end
  end

  initial begin
    int ops_done;
    int n_ops;
    int guard;
    int k;
    int pct_pick;
    int insert_pct;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_INSERT;
    in_ch.node_addr = '0;
    in_ch.port_load = '0;
    in_ch.cpu_load = '0;
    typed_check = 1'b0;
    typed_res = '0;
    error_count = 0;
    hold_token = 0;
    model_count = 0;
    ops_done = 0;

    push_row(FN_POP_MIN, 0, 0, 0, 1'b1, ST_EMPTY, 0, 0, 0, 0);
    push_row(FN_POP_MAX, 0, 0, 0, 1'b1, ST_EMPTY, 0, 0, 0, 0);
    push_row(FN_POP_MAX_ALIAS, 0, 0, 0, 1'b1, ST_EMPTY, 0, 0, 0, 0);
    push_row(FN_INSERT, 0, 0, 0, 1'b1, ST_INSERTED, 0, 0, 0, 1);
    push_row(FN_INSERT, 255, 15, 127, 1'b1, ST_INSERTED, 0, 0, 0, 2);
    push_row(FN_POP_MAX, 0, 0, 0, 1'b1, ST_POPPED, 255, 15, 127, 1);
    push_row(FN_POP_MIN, 0, 0, 0, 1'b1, ST_POPPED, 0, 0, 0, 0);
    push_row(FN_INSERT, 10, 5, 50, 1'b0, ST_INSERTED, 0, 0, 0, 0);
    push_row(FN_INSERT, 20, 5, 50, 1'b0, ST_INSERTED, 0, 0, 0, 0);
    push_row(FN_INSERT, 20, 5, 50, 1'b0, ST_INSERTED, 0, 0, 0, 0);
    push_row(FN_POP_MIN, 0, 0, 0, 1'b0, ST_INSERTED, 0, 0, 0, 0);
    push_row(FN_POP_MAX_ALIAS, 0, 0, 0, 1'b0, ST_INSERTED, 0, 0, 0, 0);
    for (k = 0; k < QUEUE_DEPTH - 1; k++) begin
      push_row(FN_INSERT, $urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 127),
               1'b0, ST_INSERTED, 0, 0, 0, 0);
    end
    push_row(FN_INSERT, 255, 15, 127, 1'b1, ST_FULL, 0, 0, 0, QUEUE_DEPTH);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      offer_op(stim_rows[i].func, stim_rows[i].rec, stim_rows[i].typed, stim_rows[i].result);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 2));
    end
    wait_drained();

    k = 0;
    while (ops_done < RANDOM_OPS) begin
      pct_pick = $urandom_range(0, 4);
      insert_pct = (pct_pick == 0) ? 85 : (pct_pick == 1) ? 20 : (pct_pick == 2) ? 50 :
                   (pct_pick == 3) ? 65 : 35;
      n_ops = $urandom_range(20, 70);
      if (n_ops > RANDOM_OPS - ops_done) begin
        n_ops = RANDOM_OPS - ops_done;
      end
      if (k == 1 || $urandom_range(0, 5) == 0) begin
        hold_token++;
      end
      run_phase(n_ops, insert_pct, $urandom_range(0, 3) == 0);
      ops_done += n_ops;
      if (k == 2 || $urandom_range(0, 2) == 0) begin
        wait_drained();
      end
      k++;
    end

    idle_cycles(1);
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    repeat (4) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[router_double_ended_priority_queue_core.f]
+incdir+sv
sv/rdpq_pkg.sv
sv/rdpq_if.sv
sv/rdpq_cell.sv
sv/router_double_ended_priority_queue_core.sv
sim/tb_router_double_ended_priority_queue_core.sv
